FILE: rtl/ping_pong_chunk_buffer_macros.svh
// Assertion helpers for the ping-pong chunk buffer
`ifndef PING_PONG_CHUNK_BUFFER_MACROS_SVH
`define PING_PONG_CHUNK_BUFFER_MACROS_SVH

// same-cycle implication
`define PPCB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPCB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ppcb_pkg.sv
package ppcb_pkg;

   localparam int BUF_BYTES  = 256;
   localparam int MAX_CHUNK  = 8;
   localparam int LANES      = 8;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ADDR_W     = $clog2(2 * BUF_BYTES);
   localparam int ROW_W      = ADDR_W - LANE_W;
   localparam int ROWS       = 2 * BUF_BYTES / LANES;
   localparam int IDX_W      = $clog2(BUF_BYTES + 1);
   localparam int SIZE_W     = 9;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 64;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_COVER = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [LEN_W-1:0]  chunk_bytes;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] read_data;
      logic              buffer_used;
   } rsp_type;

   // store access issued by the front
   typedef struct packed {
      logic              valid;
      logic              wr;
      logic              rd;
      logic              ok;
      logic              used;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } mem_op_type;

   // beat in flight between store and back
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic              used;
      logic              rd;
      logic [LEN_W-1:0]  len;
      logic [LANE_W-1:0] lane_off;
   } pend_type;

endpackage

FILE: rtl/ppcb_front.sv
module ppcb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppcb_pkg::req_type                   req_payload,
   input  logic                                csr_wr_en,
   input  logic [ppcb_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                                room,
   output ppcb_pkg::mem_op_type                op
);

   logic [ppcb_pkg::IDX_W-1:0]  fill_ff [2];
   logic [ppcb_pkg::IDX_W-1:0]  fill_in [2];
   logic [1:0]                  readable_ff, readable_in;
   logic [ppcb_pkg::IDX_W-1:0]  rpos_ff, rpos_in;
   logic [ppcb_pkg::SIZE_W-1:0] size_ff;

   logic [ppcb_pkg::IDX_W:0]    size_eff;
   logic [ppcb_pkg::IDX_W:0]    len_x;
   logic                        len_ok;
   logic                        room0, room1;
   logic                        accept;
   logic                        sel;
   logic [ppcb_pkg::IDX_W:0]    base;
   logic [ppcb_pkg::IDX_W:0]    new_fill;
   logic [ppcb_pkg::IDX_W:0]    new_rpos;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   always_comb begin
      if (size_ff == '0) begin
         size_eff = (ppcb_pkg::IDX_W + 1)'(1);
      end else if (size_ff > ppcb_pkg::SIZE_W'(ppcb_pkg::BUF_BYTES)) begin
         size_eff = (ppcb_pkg::IDX_W + 1)'(ppcb_pkg::BUF_BYTES);
      end else begin
         size_eff = (ppcb_pkg::IDX_W + 1)'(size_ff);
      end
   end

   assign len_x  = (ppcb_pkg::IDX_W + 1)'(req_payload.chunk_bytes);
   assign len_ok = (req_payload.chunk_bytes != '0)
                && (req_payload.chunk_bytes <= ppcb_pkg::LEN_W'(ppcb_pkg::MAX_CHUNK))
                && (len_x <= size_eff);
   assign room0 = !readable_ff[0] && ({1'b0, fill_ff[0]} + len_x <= size_eff);
   assign room1 = !readable_ff[1] && ({1'b0, fill_ff[1]} + len_x <= size_eff);

   always_comb begin
      fill_in     = fill_ff;
      readable_in = readable_ff;
      rpos_in     = rpos_ff;
      sel         = 1'b0;
      base        = '0;
      new_fill    = '0;
      new_rpos    = '0;
      op          = '0;
      op.valid    = accept;
      op.len      = req_payload.chunk_bytes;
      op.data     = req_payload.write_data;
      if (accept && len_ok) begin
         case (req_payload.cmd)
            ppcb_pkg::CMD_WRITE, ppcb_pkg::CMD_COVER: begin
               if (room0 || room1 || req_payload.cmd == ppcb_pkg::CMD_COVER) begin
                  // cover write empties buffer zero when nothing has room
                  sel  = !room0 && room1;
                  base = (room0 || room1) ? {1'b0, fill_ff[sel]} : '0;
                  new_fill = base + len_x;
                  fill_in[sel]     = ppcb_pkg::IDX_W'(new_fill);
                  readable_in[sel] = (new_fill >= size_eff);
                  op.wr    = 1'b1;
                  op.ok    = 1'b1;
                  op.used  = sel;
                  op.start = sel ? ppcb_pkg::ADDR_W'(ppcb_pkg::BUF_BYTES)
                                   + ppcb_pkg::ADDR_W'(base)
                                 : ppcb_pkg::ADDR_W'(base);
               end
            end
            ppcb_pkg::CMD_READ: begin
               new_rpos = {1'b0, rpos_ff} + len_x;
               if ((readable_ff[0] && {1'b0, fill_ff[0]} >= len_x
                    || readable_ff[1] && {1'b0, fill_ff[1]} >= len_x)
                   && new_rpos <= size_eff) begin
                  sel = !(readable_ff[0] && {1'b0, fill_ff[0]} >= len_x);
                  if (new_rpos >= size_eff) begin
                     rpos_in          = '0;
                     fill_in[sel]     = '0;
                     readable_in[sel] = 1'b0;
                  end else begin
                     rpos_in = ppcb_pkg::IDX_W'(new_rpos);
                  end
                  op.rd    = 1'b1;
                  op.ok    = 1'b1;
                  op.used  = sel;
                  op.start = sel ? ppcb_pkg::ADDR_W'(ppcb_pkg::BUF_BYTES)
                                   + ppcb_pkg::ADDR_W'(rpos_ff)
                                 : ppcb_pkg::ADDR_W'(rpos_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0]  <= '0;
         fill_ff[1]  <= '0;
         readable_ff <= '0;
         rpos_ff     <= '0;
         size_ff     <= ppcb_pkg::SIZE_RESET;
      end else begin
         fill_ff     <= fill_in;
         readable_ff <= readable_in;
         rpos_ff     <= rpos_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

endmodule

FILE: rtl/ppcb_store.sv
module ppcb_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ppcb_pkg::mem_op_type                  op,
   output logic [ppcb_pkg::LANES-1:0][7:0]       rdata,
   output ppcb_pkg::pend_type                    pend
);

   logic [ppcb_pkg::LANE_W-1:0] off;
   logic [ppcb_pkg::ROW_W-1:0]  base_row;
   logic [ppcb_pkg::LANES-1:0][7:0] rdata_ff;
   ppcb_pkg::pend_type          pend_ff;

   assign off      = op.start[ppcb_pkg::LANE_W-1:0];
   assign base_row = op.start[ppcb_pkg::ADDR_W-1:ppcb_pkg::LANE_W];

   // one bank per byte lane; a chunk touches each lane at most once
   for (genvar j = 0; j < ppcb_pkg::LANES; j++) begin : g_lane
      logic [7:0]                  bank [ppcb_pkg::ROWS];
      logic [ppcb_pkg::LANE_W-1:0] k;
      logic [ppcb_pkg::ROW_W-1:0]  row;
      logic                        we;

      assign k   = ppcb_pkg::LANE_W'(j) - off;
      assign row = base_row + ppcb_pkg::ROW_W'(ppcb_pkg::LANE_W'(j) < off);
      assign we  = op.valid && op.wr && (ppcb_pkg::LEN_W'(k) < op.len);

      always_ff @(posedge clock) begin
         if (we) begin
            bank[row] <= op.data[8*k +: 8];
         end
         if (op.valid && op.rd) begin
            rdata_ff[j] <= bank[row];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff.valid    <= op.valid;
         pend_ff.ok       <= op.ok;
         pend_ff.used     <= op.used;
         pend_ff.rd       <= op.rd;
         pend_ff.len      <= op.len;
         pend_ff.lane_off <= off;
      end
   end

   assign rdata = rdata_ff;
   assign pend  = pend_ff;

endmodule

FILE: rtl/ppcb_back.sv
module ppcb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ppcb_pkg::pend_type              pend,
   input  logic [ppcb_pkg::LANES-1:0][7:0] rdata,
   output logic                            room,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ppcb_pkg::rsp_type               rsp_payload
);

   ppcb_pkg::rsp_type               fifo_ff [ppcb_pkg::FIFO_DEPTH];
   logic [ppcb_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ppcb_pkg::FIFO_CNT_W-1:0] count_ff;
   logic [ppcb_pkg::DATA_W-1:0]     rd_bytes;
   ppcb_pkg::rsp_type               beat;
   logic                            push, pop;

   always_comb begin
      for (int k = 0; k < ppcb_pkg::LANES; k++) begin
         if (pend.rd && pend.ok && ppcb_pkg::LEN_W'(k) < pend.len) begin
            rd_bytes[8*k +: 8] = rdata[pend.lane_off + ppcb_pkg::LANE_W'(k)];
         end else begin
            rd_bytes[8*k +: 8] = '0;
         end
      end
   end

   assign beat.ok          = pend.ok;
   assign beat.read_data   = rd_bytes;
   assign beat.buffer_used = pend.used;

   assign push = pend.valid;
   assign pop  = rsp_valid && !rsp_stall;
   // leave a slot for the beat still in the store stage
   assign room = (count_ff + ppcb_pkg::FIFO_CNT_W'(pend.valid))
                 < ppcb_pkg::FIFO_CNT_W'(ppcb_pkg::FIFO_DEPTH);

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= beat;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + ppcb_pkg::FIFO_CNT_W'(push)
                             - ppcb_pkg::FIFO_CNT_W'(pop);
      end
   end

endmodule

FILE: rtl/ping_pong_chunk_buffer.sv
// Results are registered in the store stage, then queued. Throughput: one
// beat per cycle while the queue has room; the banked byte store (eight lanes)
// serves a whole chunk in one access; a four-entry result queue absorbs stalls.
// Reset (synchronous, active high) empties both buffers, clears the read
// position and queue, and sets the buffer size to 256; store bytes are kept.
`include "ping_pong_chunk_buffer_macros.svh"

module ping_pong_chunk_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ppcb_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ppcb_pkg::rsp_type           rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [ppcb_pkg::SIZE_W-1:0] csr_wr_data
);

   ppcb_pkg::mem_op_type            op;
   ppcb_pkg::pend_type              pend;
   logic [ppcb_pkg::LANES-1:0][7:0] rdata;
   logic                            room;

   ppcb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .room        (room),
      .op          (op)
   );

   ppcb_store u_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .rdata (rdata),
      .pend  (pend)
   );

   ppcb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pend        (pend),
      .rdata       (rdata),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `PPCB_ASSERT_NEXT(a_accept_reaches_store, clock, reset, req_valid && !req_stall, pend.valid, "accepted beat missing in store stage")
   `PPCB_ASSERT_NOW(a_fail_is_zero, clock, reset, rsp_valid && !rsp_payload.ok, rsp_payload.read_data == '0 && !rsp_payload.buffer_used, "failed beat carries data")
   `PPCB_ASSERT_NOW(a_empty_queue_takes, clock, reset, !rsp_valid, !req_stall, "stall with empty result queue")

endmodule
